@@ rtl/clook_pkg.sv @@
`timescale 1ns / 1ps

package clook_pkg;

    localparam int SECTOR_W        = 48;
    localparam int TAG_W           = 8;
    localparam int STATUS_W        = 3;
    localparam int QCOUNT_W        = 5;
    localparam int QUEUE_DEPTH_DEF = 16;

    localparam logic ACT_ADD      = 1'b0;
    localparam logic ACT_DISPATCH = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED   = 3'd0,
        ST_MERGED     = 3'd1,
        ST_FULL       = 3'd2,
        ST_DISPATCHED = 3'd3,
        ST_EMPTY      = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISP,
        S_SCAN,
        S_SHIFT,
        S_POST
    } t_state;

    typedef struct packed {
        logic                action;
        logic [SECTOR_W-1:0] sector;
        logic [TAG_W-1:0]    req_tag;
    } t_in_item;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SECTOR_W-1:0] out_sector;
        logic [TAG_W-1:0]    out_tag;
        logic [QCOUNT_W-1:0] queue_count;
    } t_out_item;

    // one queue entry as held in the entry RAM
    typedef struct packed {
        logic [SECTOR_W-1:0] sector;
        logic [TAG_W-1:0]    tag;
    } t_entry;

endpackage

@@ rtl/clook_disk_request_scheduler.sv @@
`timescale 1ns / 1ps

// C-LOOK disk request scheduler. Holds up to QUEUE_DEPTH requests (sector,
// tag) in one circular entry RAM, ordered for a circular-LOOK sweep from the
// head (sector of the last dispatched request, all ones after reset). An
// add transaction (action 0) walks the queue front to back, one RAM read per
// cycle, to find its slot or, for a below-head sector, a below-head entry
// with the same sector or the next one up to merge into (reported with that
// entry's tag, queue unchanged). It then opens the slot by moving the later
// entries up one place, one entry per cycle through the single RAM read and
// write ports, and writes the new entry. A dispatch transaction (action 1)
// pops the front entry and moves the head; the pop only advances a base
// pointer. Every input transaction yields exactly one result transaction.
// The block takes one transaction at a time. A dispatch reads the front
// entry, then posts its result; on an empty queue it posts the empty
// result directly. A merge or a full-queue rejection ends after the scan;
// an insert ends after the shift and the write of the new entry. A
// finished result sits in an output register, so the input side frees up
// as soon as that register can take it; while the output stalls, the
// block holds the result and takes no new transaction.
module clook_disk_request_scheduler #(
    parameter int QUEUE_DEPTH = clook_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // request channel
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  clook_pkg::t_in_item i_in_data,
    // result channel
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output clook_pkg::t_out_item o_out_data
);
    import clook_pkg::*;

    localparam int IW = $clog2(QUEUE_DEPTH);       // RAM index width
    localparam int CW = $clog2(QUEUE_DEPTH + 1);   // fill count width
    localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);

    // Logical queue position to RAM address: base + offset, wrapped once.
    function automatic logic [IW-1:0] phys(input logic [IW-1:0] base,
                                           input logic [CW-1:0] li);
        logic [CW:0] sum;
        sum = (CW+1)'(base) + (CW+1)'(li);
        if (sum >= (CW+1)'(QUEUE_DEPTH)) begin
            sum = sum - (CW+1)'(QUEUE_DEPTH);
        end
        return sum[IW-1:0];
    endfunction

    // control state
    t_state              r_state, n_state;
    logic [CW-1:0]       r_count, n_count;     // entries held
    logic [IW-1:0]       r_base,  n_base;      // RAM address of queue front
    logic [SECTOR_W-1:0] r_head,  n_head;      // last dispatched sector
    logic                r_pend,  n_pend;      // RAM read in flight
    logic                r_o_valid, n_o_valid;

    // working registers of the current transaction
    logic [SECTOR_W-1:0] r_sec,    n_sec;
    logic [SECTOR_W:0]   r_sec_p1, n_sec_p1;   // sector + 1, no wrap
    logic [TAG_W-1:0]    r_tag,    n_tag;
    logic                r_below,  n_below;    // sector below head
    logic [CW-1:0]       r_ridx,   n_ridx;     // scan: next position to read
    logic [CW-1:0]       r_cidx,   n_cidx;     // scan: position of read data
    logic [CW-1:0]       r_pos,    n_pos;      // insertion slot
    logic [CW-1:0]       r_j,      n_j;        // shift: slot being opened
    logic [CW-1:0]       r_wj,     n_wj;       // shift: target of read data
    t_out_item           r_res,    n_res;      // finished result
    t_out_item           r_o_data, n_o_data;

    // entry RAM ports
    logic          ram_we;
    logic [IW-1:0] ram_waddr;
    t_entry        ram_wdata;
    logic [IW-1:0] ram_raddr;
    t_entry        ram_rdata;

    // scan compare of the entry just read
    logic c_below, c_merge, c_ins, out_free;
    logic [CW-1:0] j_m1;

    clook_entry_ram #(
        .DEPTH (QUEUE_DEPTH),
        .AW    (IW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        c_below = ram_rdata.sector < r_head;
        c_merge = r_below && c_below &&
                  ((r_sec == ram_rdata.sector) || (r_sec_p1 == {1'b0, ram_rdata.sector}));
        // below head: first below-head entry above us; else first below-head
        // entry or first entry above us
        c_ins   = r_below ? (c_below && (r_sec < ram_rdata.sector))
                          : (c_below || (r_sec < ram_rdata.sector));
        j_m1    = (r_j != '0) ? (r_j - 1'b1) : '0;
        out_free = !r_o_valid || !i_out_stall;
    end

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_base    = r_base;
        n_head    = r_head;
        n_pend    = r_pend;
        n_sec     = r_sec;
        n_sec_p1  = r_sec_p1;
        n_tag     = r_tag;
        n_below   = r_below;
        n_ridx    = r_ridx;
        n_cidx    = r_cidx;
        n_pos     = r_pos;
        n_j       = r_j;
        n_wj      = r_wj;
        n_res     = r_res;
        n_o_data  = r_o_data;
        n_o_valid = r_o_valid && i_out_stall;

        ram_we    = 1'b0;
        ram_waddr = phys(r_base, r_wj);
        ram_wdata = ram_rdata;
        ram_raddr = phys(r_base, r_ridx);

        unique case (r_state)
            S_IDLE: begin
                ram_raddr = r_base;   // front entry, used by a dispatch
                if (i_in_valid) begin
                    n_sec    = i_in_data.sector;
                    n_sec_p1 = {1'b0, i_in_data.sector} + 1'b1;
                    n_tag    = i_in_data.req_tag;
                    n_below  = i_in_data.sector < r_head;
                    n_ridx   = '0;
                    n_pend   = 1'b0;
                    if (i_in_data.action == ACT_DISPATCH) begin
                        if (r_count == '0) begin
                            n_res   = '{status: ST_EMPTY, out_sector: '0, out_tag: '0,
                                        queue_count: QCOUNT_W'(r_count)};
                            n_state = S_POST;
                        end else begin
                            n_state = S_DISP;
                        end
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end

            S_DISP: begin
                n_head  = ram_rdata.sector;
                n_base  = phys(r_base, CW'(1));
                n_count = r_count - 1'b1;
                n_res   = '{status: ST_DISPATCHED, out_sector: ram_rdata.sector,
                            out_tag: ram_rdata.tag,
                            queue_count: QCOUNT_W'(r_count - 1'b1)};
                n_state = S_POST;
            end

            S_SCAN: begin
                if (r_pend && c_merge) begin
                    n_res   = '{status: ST_MERGED, out_sector: '0, out_tag: ram_rdata.tag,
                                queue_count: QCOUNT_W'(r_count)};
                    n_pend  = 1'b0;
                    n_state = S_POST;
                end else if ((r_pend && c_ins) || (!r_pend && (r_ridx >= r_count))) begin
                    // slot found, or ran off the end of the queue
                    n_pend = 1'b0;
                    if (r_count >= DEPTH_C) begin
                        n_res   = '{status: ST_FULL, out_sector: '0, out_tag: '0,
                                    queue_count: QCOUNT_W'(r_count)};
                        n_state = S_POST;
                    end else begin
                        n_pos   = r_pend ? r_cidx : r_count;
                        n_j     = r_count;
                        n_state = S_SHIFT;
                    end
                end else begin
                    // read the next entry while checking this one
                    n_pend = r_ridx < r_count;
                    n_cidx = r_ridx;
                    if (r_ridx < r_count) begin
                        n_ridx = r_ridx + 1'b1;
                    end
                end
            end

            S_SHIFT: begin
                ram_raddr = phys(r_base, j_m1);
                if (r_pend) begin
                    ram_we    = 1'b1;
                    ram_waddr = phys(r_base, r_wj);
                    ram_wdata = ram_rdata;
                end
                if (r_j != r_pos) begin
                    n_pend = 1'b1;
                    n_wj   = r_j;
                    n_j    = j_m1;
                end else if (r_pend) begin
                    n_pend = 1'b0;   // last moved entry lands this cycle
                end else begin
                    ram_we    = 1'b1;
                    ram_waddr = phys(r_base, r_pos);
                    ram_wdata = '{sector: r_sec, tag: r_tag};
                    n_count   = r_count + 1'b1;
                    n_res     = '{status: ST_INSERTED, out_sector: '0, out_tag: '0,
                                  queue_count: QCOUNT_W'(r_count + 1'b1)};
                    n_state   = S_POST;
                end
            end

            S_POST: begin
                if (out_free) begin
                    n_o_valid = 1'b1;
                    n_o_data  = r_res;
                    n_state   = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_base    <= '0;
            r_head    <= '1;
            r_pend    <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_base    <= n_base;
            r_head    <= n_head;
            r_pend    <= n_pend;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sec    <= n_sec;
        r_sec_p1 <= n_sec_p1;
        r_tag    <= n_tag;
        r_below  <= n_below;
        r_ridx   <= n_ridx;
        r_cidx   <= n_cidx;
        r_pos    <= n_pos;
        r_j      <= n_j;
        r_wj     <= n_wj;
        r_res    <= n_res;
        r_o_data <= n_o_data;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_o_valid;
    assign o_out_data  = r_o_data;

`ifndef ASSERT_OFF
    a_count_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= DEPTH_C)
        else $error("queue fill count above depth");

    a_shift_order : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SHIFT) |-> ((r_j >= r_pos) && (r_count < DEPTH_C)))
        else $error("shift pointer passed the insertion slot");

    a_write_owner : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_state == S_SHIFT))
        else $error("entry RAM written outside the shift phase");

    a_pop_nonempty : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DISP) |=> (r_count == $past(r_count) - 1'b1))
        else $error("dispatch did not drop exactly one entry");
`endif

endmodule

@@ rtl/clook_entry_ram.sv @@
`timescale 1ns / 1ps

module clook_entry_ram #(
    parameter int DEPTH = 16,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [AW-1:0]     i_waddr,
    input  clook_pkg::t_entry i_wdata,
    input  logic [AW-1:0]     i_raddr,
    output clook_pkg::t_entry o_rdata
);
    import clook_pkg::*;

    t_entry mem [DEPTH];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
